FILE: src/dbss_pkg.sv
`timescale 1ns / 1ps

package dbss_pkg;

  // Default geometry of the store.
  localparam int DEPTH_DEF      = 1024;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 16;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Every byte of a word holds 'S' after reset; narrower words take the low bits.
  localparam logic [63:0] FILL_PATTERN = 64'h5353_5353_5353_5353;

  // Index bits folded into the remainder per cycle.
  localparam int REM_BITS = 4;

  // Per-entry mark naming the bank that was last written.
  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_FIRST  = 2'd1;
  localparam logic [1:0] MARK_SECOND = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CKPT  = 2'd2,
    CMD_SNAP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic clear_en;     // write the fill pattern at the clear counter
    logic capture;      // take the input transaction, start the remainder
    logic sweep_start;  // flip the active bank and arm the sweep
    logic sweep_en;     // run the checkpoint sweep
    logic access;       // single memory access for the captured command
    logic load_out;     // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rem_done;
    logic sweep_done;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: src/dbss_ram.sv
`timescale 1ns / 1ps

module dbss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/dbss_rem.sv
`timescale 1ns / 1ps

module dbss_rem #(
  parameter int CW = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [dbss_pkg::IDX_W-1:0] dividend,
  input  logic [CW-1:0]            divisor,
  output logic                     done,
  output logic [CW-1:0]            rem
);

  localparam int STEPS = dbss_pkg::IDX_W / dbss_pkg::REM_BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [CW-1:0]              rem_r, rem_nxt;
  logic [dbss_pkg::IDX_W-1:0] dvd_r, dvd_nxt;
  logic [SW-1:0]              step_r;
  logic                       busy_r;
  logic                       done_r;
  logic [CW:0]                trial;

  // Restoring remainder: shift in one dividend bit, subtract when it fits.
  // The partial remainder stays below the divisor, so the trial is below twice it.
  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    trial   = '0;
    for (int k = 0; k < dbss_pkg::REM_BITS; k++) begin
      trial   = {rem_nxt, dvd_nxt[dbss_pkg::IDX_W-1]};
      dvd_nxt = {dvd_nxt[dbss_pkg::IDX_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      step_r <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      step_r <= step_r + SW'(1);
      if (step_r == SW'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: src/dbss_dp.sv
`timescale 1ns / 1ps

module dbss_dp #(
  parameter int DEPTH      = dbss_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = dbss_pkg::WORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dbss_pkg::ctrl_cmd_t         ctl,
  output dbss_pkg::ctrl_status_t      sts,
  input  logic [dbss_pkg::CMD_W-1:0]  in_cmd,
  input  logic [dbss_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [dbss_pkg::DATA_W-1:0] in_write_value,
  input  logic                        cfg_valid,
  input  logic [dbss_pkg::CFG_W-1:0]  cfg_entries_in_use,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dbss_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_active_bank
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [WORD_WIDTH-1:0] FILL_WORD = WORD_WIDTH'(dbss_pkg::FILL_PATTERN);

  logic [dbss_pkg::CFG_W-1:0] entries_r;
  logic [CW-1:0]              live_n;

  dbss_pkg::cmd_t             cmd_r;
  logic [WORD_WIDTH-1:0]      wval_r;
  logic                       active_r;

  logic [AW-1:0]              clr_cnt_r;
  logic [CW-1:0]              sweep_cnt_r;
  logic                       pipe_vld_r;
  logic [AW-1:0]              pipe_addr_r;
  logic                       sweep_issue;
  logic                       sweep_wr;
  logic [1:0]                 cur_mark;

  logic                       rem_done;
  logic [CW-1:0]              rem;
  logic [AW-1:0]              idx;
  logic                       item_write;

  logic [AW-1:0]              raddr;
  logic                       b0_we, b1_we, mk_we;
  logic [AW-1:0]              b0_waddr, b1_waddr, mk_waddr;
  logic [WORD_WIDTH-1:0]      b0_wdata, b1_wdata;
  logic [1:0]                 mk_wdata;
  logic [WORD_WIDTH-1:0]      b0_rdata, b1_rdata;
  logic [1:0]                 mk_rdata;
  logic [WORD_WIDTH-1:0]      result_word;

  logic                       out_valid_r;
  logic [dbss_pkg::DATA_W-1:0] out_data_r;
  logic                       out_bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= dbss_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      entries_r <= cfg_entries_in_use;
    end
  end

  // Zero entries count as one, counts above the depth as the depth.
  always_comb begin
    if (entries_r == '0) begin
      live_n = CW'(1);
    end else if (32'(entries_r) > 32'(DEPTH)) begin
      live_n = CW'(DEPTH);
    end else begin
      live_n = CW'(entries_r);
    end
  end

  dbss_rem #(
    .CW(CW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.capture),
    .dividend (in_entry_index),
    .divisor  (live_n),
    .done     (rem_done),
    .rem      (rem)
  );

  assign idx = rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= dbss_pkg::cmd_t'(in_cmd);
      wval_r <= WORD_WIDTH'(in_write_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (ctl.sweep_start) begin
      active_r <= ~active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clear_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // The sweep reads entry i while it writes back entry i-1 from the read data.
  assign sweep_issue = ctl.sweep_en && (sweep_cnt_r < live_n);
  assign cur_mark    = active_r ? dbss_pkg::MARK_SECOND : dbss_pkg::MARK_FIRST;
  assign sweep_wr    = pipe_vld_r && (mk_rdata != cur_mark);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      pipe_vld_r  <= 1'b0;
    end else if (ctl.sweep_start) begin
      sweep_cnt_r <= '0;
      pipe_vld_r  <= 1'b0;
    end else begin
      pipe_vld_r <= sweep_issue;
      if (sweep_issue) begin
        sweep_cnt_r <= sweep_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr_r <= sweep_cnt_r[AW-1:0];
  end

  assign item_write = ctl.access && (cmd_r == dbss_pkg::CMD_WRITE);
  assign raddr      = ctl.sweep_en ? sweep_cnt_r[AW-1:0] : idx;

  always_comb begin
    b0_we    = ctl.clear_en || (!active_r && (item_write || sweep_wr));
    b1_we    = ctl.clear_en || (active_r && (item_write || sweep_wr));
    mk_we    = ctl.clear_en || item_write || sweep_wr;
    if (ctl.clear_en) begin
      b0_waddr = clr_cnt_r;
      b0_wdata = FILL_WORD;
      b1_wdata = FILL_WORD;
      mk_wdata = dbss_pkg::MARK_NONE;
    end else if (sweep_wr) begin
      b0_waddr = pipe_addr_r;
      b0_wdata = b1_rdata;
      b1_wdata = b0_rdata;
      mk_wdata = dbss_pkg::MARK_NONE;
    end else begin
      b0_waddr = idx;
      b0_wdata = wval_r;
      b1_wdata = wval_r;
      mk_wdata = cur_mark;
    end
    b1_waddr = b0_waddr;
    mk_waddr = b0_waddr;
  end

  dbss_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_bank_first (
    .clk   (clk),
    .we    (b0_we),
    .waddr (b0_waddr),
    .wdata (b0_wdata),
    .raddr (raddr),
    .rdata (b0_rdata)
  );

  dbss_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_bank_second (
    .clk   (clk),
    .we    (b1_we),
    .waddr (b1_waddr),
    .wdata (b1_wdata),
    .raddr (raddr),
    .rdata (b1_rdata)
  );

  dbss_ram #(
    .WIDTH(2),
    .DEPTH(DEPTH)
  ) u_mark (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .raddr (raddr),
    .rdata (mk_rdata)
  );

  always_comb begin
    case (cmd_r)
      dbss_pkg::CMD_READ: result_word = active_r ? b1_rdata : b0_rdata;
      dbss_pkg::CMD_SNAP: result_word = active_r ? b0_rdata : b1_rdata;
      default:            result_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data_r <= dbss_pkg::DATA_W'(result_word);
      out_bank_r <= active_r;
    end
  end

  assign sts.clear_last = clr_cnt_r == AW'(DEPTH - 1);
  assign sts.rem_done   = rem_done;
  assign sts.sweep_done = ctl.sweep_en && !sweep_issue && !pipe_vld_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_active_bank = out_bank_r;

endmodule

FILE: src/dbss_ctrl.sv
`timescale 1ns / 1ps

module dbss_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dbss_pkg::CMD_W-1:0] in_cmd,
  output dbss_pkg::ctrl_cmd_t        ctl,
  input  dbss_pkg::ctrl_status_t     sts
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_REM    = 6'b000100,
    S_ACCESS = 6'b001000,
    S_SWEEP  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          if (dbss_pkg::cmd_t'(in_cmd) == dbss_pkg::CMD_CKPT) begin
            ctl.sweep_start = 1'b1;
            state_nxt       = S_SWEEP;
          end else begin
            state_nxt = S_REM;
          end
        end
      end
      S_REM: begin
        if (sts.rem_done) begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        ctl.access = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_SWEEP: begin
        ctl.sweep_en = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: src/dual_bank_snapshot_store.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_cmd, in_entry_index, in_write_value
// out      output     out_valid / out_ready  out_read_data, out_active_bank
// cfg      input      cfg_valid / cfg_ready  cfg_entries_in_use
//
// Read, write and snapshot read go through accept, the index remainder
// (4 index bits a cycle), one memory access and a load of the output register.
// A checkpoint flips the active bank; its sweep reads one entry a cycle through the
// simple dual-port bank and mark memories and writes back each entry not marked for the new bank.
// After reset a clearing pass fills every entry of the memories; in_ready stays low.
// A waiting result sits in the output register while the next transaction is taken.

module dual_bank_snapshot_store #(
  parameter int DEPTH      = dbss_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = dbss_pkg::WORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dbss_pkg::CMD_W-1:0]  in_cmd,
  input  logic [dbss_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [dbss_pkg::DATA_W-1:0] in_write_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dbss_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_active_bank,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dbss_pkg::CFG_W-1:0]  cfg_entries_in_use
);

  dbss_pkg::ctrl_cmd_t    ctl;
  dbss_pkg::ctrl_status_t sts;

  assign cfg_ready = 1'b1;

  dbss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .ctl      (ctl),
    .sts      (sts)
  );

  dbss_dp #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_write_value     (in_write_value),
    .cfg_valid          (cfg_valid),
    .cfg_entries_in_use (cfg_entries_in_use),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_active_bank    (out_active_bank)
  );

endmodule

FILE: tb/sv/dbss_checker.sv
`timescale 1ns / 1ps

module dbss_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [dbss_pkg::CMD_W-1:0]  in_cmd,
  input  logic [dbss_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [dbss_pkg::DATA_W-1:0] in_write_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [dbss_pkg::DATA_W-1:0] out_read_data,
  input  logic                        out_active_bank,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [dbss_pkg::CFG_W-1:0]  cfg_entries_in_use,
  output int unsigned                 fail_count,
  output int unsigned                 pending
);

  import dbss_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              bank;
  } store_reply_t;

  logic [DATA_W-1:0] bank_first_m  [DEPTH_DEF];
  logic [DATA_W-1:0] bank_second_m [DEPTH_DEF];
  logic [1:0]        mark_m        [DEPTH_DEF];
  logic              active_m;
  logic [CFG_W-1:0]  entries_m;
  store_reply_t      replies_q [$];

  function automatic int unsigned live_entries();
    if (entries_m == '0) return 1;
    if (entries_m > DEPTH_DEF) return DEPTH_DEF;
    return entries_m;
  endfunction

  // Applies one transaction to the local copy of the store and returns its reply.
  function automatic store_reply_t apply_command(cmd_t cmd, logic [IDX_W-1:0] raw_index,
                                                 logic [DATA_W-1:0] value);
    store_reply_t     reply;
    int unsigned      n;
    int unsigned      slot;
    logic [1:0]       keep_mark;
    n = live_entries();
    slot = raw_index % n;
    reply.word = '0;
    case (cmd)
      CMD_READ: begin
        reply.word = active_m ? bank_second_m[slot] : bank_first_m[slot];
      end
      CMD_WRITE: begin
        if (active_m) begin
          bank_second_m[slot] = value;
          mark_m[slot] = MARK_SECOND;
        end else begin
          bank_first_m[slot] = value;
          mark_m[slot] = MARK_FIRST;
        end
      end
      CMD_CKPT: begin
        active_m = ~active_m;
        keep_mark = active_m ? MARK_SECOND : MARK_FIRST;
        // Entries not written in the new online bank, including never-written
        // ones, take the backup word and lose their mark.
        for (int i = 0; i < n; i++) begin
          if (mark_m[i] != keep_mark) begin
            if (active_m) bank_second_m[i] = bank_first_m[i];
            else bank_first_m[i] = bank_second_m[i];
            mark_m[i] = MARK_NONE;
          end
        end
      end
      default: begin
        reply.word = active_m ? bank_first_m[slot] : bank_second_m[slot];
      end
    endcase
    reply.bank = active_m;
    return reply;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    store_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH_DEF; i++) begin
        bank_first_m[i] = FILL_PATTERN[DATA_W-1:0];
        bank_second_m[i] = FILL_PATTERN[DATA_W-1:0];
        mark_m[i] = MARK_NONE;
      end
      active_m = 1'b0;
      entries_m = CFG_RESET;
      replies_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (replies_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual read_data %h bank %0d",
                   $time, out_read_data, out_active_bank);
        end else begin
          want = replies_q.pop_front();
          if (out_read_data !== want.word) begin
            fail_count++;
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want.word, out_read_data);
          end
          if (out_active_bank !== want.bank) begin
            fail_count++;
            $display("%0t: active_bank mismatch: expected %0d, actual %0d",
                     $time, want.bank, out_active_bank);
          end
        end
      end
      if (cfg_valid && cfg_ready) entries_m = cfg_entries_in_use;
      if (in_valid && in_ready)
        replies_q.push_back(apply_command(cmd_t'(in_cmd), in_entry_index, in_write_value));
    end
    pending = replies_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import dbss_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned CALM_ITEMS   = 200;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd;
  logic [IDX_W-1:0]  in_entry_index;
  logic [DATA_W-1:0] in_write_value;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_read_data;
  logic              out_active_bank;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_entries_in_use;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count;
  int unsigned cycle_count;
  logic        calm_tail;
  logic        gaps_on;

  dual_bank_snapshot_store i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_active_bank    (out_active_bank),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  dbss_checker i_store_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_active_bank    (out_active_bank),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offers one transaction, possibly after an idle burst, and waits until it is taken.
  task automatic offer_command(cmd_t cmd, logic [IDX_W-1:0] index, logic [DATA_W-1:0] value);
    int unsigned gap;
    @(negedge clk);
    if (gaps_on && !calm_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_index <= index;
    in_write_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // The size register is only changed once every reply has come back.
  task automatic set_entries(logic [CFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_entries_in_use <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned burst;
    int unsigned mode_left;
    logic        busy;
    logic        held_once;
    out_ready <= 1'b0;
    busy = 1'b0;
    mode_left = 0;
    held_once = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        busy = 1'($urandom_range(0, 1));
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (!held_once && sent_count >= 150) begin
        // Long hold-off: the block fills up and has to stall its input.
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (busy && !calm_tail && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned      rand_sent;
    int unsigned      phase_no;
    int unsigned      phase_items;
    int unsigned      n_eff;
    int unsigned      roll;
    int unsigned      ckpt_pct;
    logic [CFG_W-1:0] size_sel;
    cmd_t             pick;
    logic [IDX_W-1:0] index;
    logic [DATA_W-1:0] word;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_READ;
    in_entry_index = '0;
    in_write_value = '0;
    cfg_valid = 1'b0;
    cfg_entries_in_use = '0;
    sent_count = 0;
    calm_tail = 1'b0;
    gaps_on = 1'b1;
    n_eff = DEPTH_DEF;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 1024 entries.
    offer_command(CMD_READ, 16'd0, '0);
    offer_command(CMD_SNAP, 16'hFFFF, '0);
    offer_command(CMD_WRITE, 16'd0, 32'hFFFF_FFFF);
    offer_command(CMD_WRITE, 16'hFFFF, 32'h0000_0000);
    offer_command(CMD_READ, 16'd1024, '0);
    offer_command(CMD_READ, 16'd1023, '0);
    offer_command(CMD_SNAP, 16'd0, '0);
    offer_command(CMD_WRITE, 16'd5, 32'hA5A5_5A5A);
    offer_command(CMD_CKPT, 16'd0, '0);
    offer_command(CMD_READ, 16'd0, '0);
    offer_command(CMD_SNAP, 16'd5, '0);
    offer_command(CMD_WRITE, 16'd0, 32'h1234_5678);
    offer_command(CMD_WRITE, 16'd7, 32'h8000_0001);
    offer_command(CMD_READ, 16'd7, '0);
    offer_command(CMD_CKPT, 16'hFFFF, 32'hFFFF_FFFF);
    offer_command(CMD_READ, 16'd0, '0);
    offer_command(CMD_SNAP, 16'd7, '0);
    offer_command(CMD_WRITE, 16'd3, 32'h0F0F_F0F0);
    offer_command(CMD_CKPT, 16'd3, '0);
    offer_command(CMD_READ, 16'd3, '0);
    offer_command(CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    offer_command(CMD_SNAP, 16'hFFFF, '0);

    rand_sent = 0;
    phase_no = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      // The size stays fixed in the last part so the input never drains there.
      if (!calm_tail) begin
        case (phase_no)
          0: size_sel = 11'd1;
          1: size_sel = 11'd2047;
          2: size_sel = 11'd2;
          3: size_sel = 11'd0;
          4: size_sel = 11'd1025;
          5: size_sel = 11'd7;
          6: size_sel = 11'd1024;
          7: size_sel = 11'd3;
          default: begin
            if (phase_no % 6 == 0) size_sel = CFG_W'($urandom_range(0, 1));
            else size_sel = CFG_W'($urandom_range(1, 48));
          end
        endcase
        set_entries(size_sel);
        if (size_sel == '0) n_eff = 1;
        else if (size_sel > DEPTH_DEF) n_eff = DEPTH_DEF;
        else n_eff = size_sel;
      end
      // Wide settings make checkpoints slow, so their phases stay short.
      phase_items = (n_eff > 64) ? 30 : $urandom_range(40, 70);
      ckpt_pct = (n_eff > 64) ? 3 : 8;
      gaps_on = $urandom_range(0, 3) != 0;
      for (int k = 0; k < phase_items && rand_sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < ckpt_pct) pick = CMD_CKPT;
        else if (roll < ckpt_pct + 35) pick = CMD_READ;
        else if (roll < ckpt_pct + 70) pick = CMD_WRITE;
        else pick = CMD_SNAP;
        if ($urandom_range(0, 1) == 0) index = IDX_W'($urandom_range(0, n_eff + 1));
        else index = IDX_W'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 9))
          0: word = '0;
          1: word = '1;
          default: word = $urandom();
        endcase
        offer_command(pick, index, word);
        rand_sent++;
        if (rand_sent >= RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
      end
      phase_no++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/dbss_pkg.sv
src/dbss_ram.sv
src/dbss_rem.sv
src/dbss_dp.sv
src/dbss_ctrl.sv
src/dual_bank_snapshot_store.sv
tb/sv/dbss_checker.sv
tb/sv/tb_top.sv
